[hw/rtl/dmb_pkg.sv]
// ----------------------------------------------------------------------------
// dmb_pkg
// Shared types and constants for the debounced button MIDI event block.
// ----------------------------------------------------------------------------
package dmb_pkg;

  // Default number of buttons served
  localparam int unsigned ButtonCountDef = 16;

  // Configuration port geometry: 64-bit registers at 8-byte spacing
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;

  // Debounce history patterns (bit 7 always forced)
  localparam logic [7:0] HistForce = 8'h80;
  localparam logic [7:0] HistHigh  = 8'hFF;

  // Register indexes
  typedef enum logic [2:0] {
    REG_LATCHING_MASK  = 3'd0,
    REG_PC_MASK        = 3'd1,
    REG_NUMBERS_LOW    = 3'd2,
    REG_NUMBERS_HIGH   = 3'd3,
    REG_VELOCITY_ON    = 3'd4,
    REG_VELOCITY_OFF   = 3'd5,
    REG_ID_REPORT      = 3'd6
  } reg_e;

  // MIDI message kinds
  typedef enum logic [1:0] {
    KIND_NOTE_ON      = 2'd0,
    KIND_NOTE_OFF     = 2'd1,
    KIND_PROG_CHANGE  = 2'd2
  } kind_e;

  // Input transaction
  typedef struct packed {
    logic [3:0] button_index;
    logic       raw_level;
  } dmb_in_t;

  // Output transaction
  typedef struct packed {
    kind_e      message_kind;
    logic [6:0] midi_number;
    logic [6:0] velocity;
    logic [3:0] source_button;
    logic       report_id;
  } dmb_out_t;

  // Register file contents seen by the event logic
  typedef struct packed {
    logic [15:0] latching_mask;
    logic [15:0] program_change_mask;
    logic [62:0] numbers_low;
    logic [62:0] numbers_high;
    logic [6:0]  velocity_on_value;
    logic [6:0]  velocity_off_value;
    logic        id_report_enable;
  } dmb_cfg_t;

  // Event logic result toward the output register
  typedef struct packed {
    logic     valid;
    dmb_out_t item;
  } dmb_res_t;

endpackage

[hw/rtl/dmb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dmb_cfg_regs
// APB-style configuration registers for the button event block.
// ----------------------------------------------------------------------------
module dmb_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmb_pkg::CfgAddrW-1:0]  paddr,
  input  logic [dmb_pkg::CfgDataW-1:0]  pwdata,
  output logic [dmb_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output dmb_pkg::dmb_cfg_t             cfg_o
);
  import dmb_pkg::*;

  // Register values after reset: velocity-on full scale, all else zero
  localparam dmb_cfg_t CfgReset = '{
    latching_mask:       16'd0,
    program_change_mask: 16'd0,
    numbers_low:         63'd0,
    numbers_high:        63'd0,
    velocity_on_value:   7'd127,
    velocity_off_value:  7'd0,
    id_report_enable:    1'b0
  };

  dmb_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  reg_e     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[CfgAddrW-1:3]);

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_LATCHING_MASK: cfg_d.latching_mask       = pwdata[15:0];
        REG_PC_MASK:       cfg_d.program_change_mask = pwdata[15:0];
        REG_NUMBERS_LOW:   cfg_d.numbers_low         = pwdata[62:0];
        REG_NUMBERS_HIGH:  cfg_d.numbers_high        = pwdata[62:0];
        REG_VELOCITY_ON:   cfg_d.velocity_on_value   = pwdata[6:0];
        REG_VELOCITY_OFF:  cfg_d.velocity_off_value  = pwdata[6:0];
        REG_ID_REPORT:     cfg_d.id_report_enable    = pwdata[0];
        default: ;
      endcase
    end
  end

  // Read decode
  always_comb begin
    unique case (reg_sel)
      REG_LATCHING_MASK: prdata = {48'b0, cfg_q.latching_mask};
      REG_PC_MASK:       prdata = {48'b0, cfg_q.program_change_mask};
      REG_NUMBERS_LOW:   prdata = {1'b0, cfg_q.numbers_low};
      REG_NUMBERS_HIGH:  prdata = {1'b0, cfg_q.numbers_high};
      REG_VELOCITY_ON:   prdata = {57'b0, cfg_q.velocity_on_value};
      REG_VELOCITY_OFF:  prdata = {57'b0, cfg_q.velocity_off_value};
      REG_ID_REPORT:     prdata = {63'b0, cfg_q.id_report_enable};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/dmb_core.sv]
// ----------------------------------------------------------------------------
// dmb_core
// Per-button debounce history, press and level state, and MIDI event logic.
// ----------------------------------------------------------------------------
module dmb_core #(
  parameter int unsigned BUTTON_COUNT = dmb_pkg::ButtonCountDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  dmb_pkg::dmb_in_t  item_i,
  input  dmb_pkg::dmb_cfg_t cfg_i,
  output dmb_pkg::dmb_res_t res_o
);
  import dmb_pkg::*;

  localparam int unsigned IdxW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  logic [7:0] hist_q    [BUTTON_COUNT];
  logic       pressed_q [BUTTON_COUNT];
  logic       last_q    [BUTTON_COUNT];

  logic [IdxW-1:0] ix;
  logic [3:0]      bi;
  logic            lvl;
  logic            in_range;
  logic [7:0]      hist_old;
  logic [7:0]      hist_new;
  logic            pressed_old;
  logic            pressed_nx;
  logic            last_old;
  logic            deb;
  logic            latch;
  logic            pc;
  logic            emit;
  kind_e           kind;
  logic [62:0]     word;
  logic [6:0]      vel;

  assign bi       = item_i.button_index;
  assign lvl      = item_i.raw_level;
  assign ix       = bi[IdxW-1:0];
  assign in_range = (5'(bi) < 5'(BUTTON_COUNT));

  assign hist_old    = hist_q[ix];
  assign pressed_old = pressed_q[ix];
  assign last_old    = last_q[ix];

  // Shift in the new sample, force the top bit
  assign hist_new = {1'b1, hist_old[5:0], lvl};
  assign deb      = (hist_new == HistForce) || (hist_new == HistHigh);

  assign latch = cfg_i.latching_mask[bi];
  assign pc    = cfg_i.program_change_mask[bi];

  // Momentary / latching handling
  always_comb begin
    emit       = 1'b0;
    kind       = KIND_NOTE_ON;
    pressed_nx = pressed_old;
    if (latch) begin
      if (lvl && !last_old) begin
        emit       = 1'b1;
        kind       = pressed_old ? KIND_NOTE_OFF : KIND_NOTE_ON;
        pressed_nx = !pressed_old;
      end
    end else if (lvl) begin
      if (!pressed_old) begin
        emit       = 1'b1;
        pressed_nx = 1'b1;
        kind       = pc ? KIND_PROG_CHANGE : KIND_NOTE_ON;
      end
    end else if (pressed_old) begin
      emit       = !pc;
      kind       = KIND_NOTE_OFF;
      pressed_nx = 1'b0;
    end
  end

  // Velocity per kind
  always_comb begin
    case (kind)
      KIND_NOTE_ON:  vel = cfg_i.velocity_on_value;
      KIND_NOTE_OFF: vel = cfg_i.velocity_off_value;
      default:       vel = 7'd0;
    endcase
  end

  // Number byte lookup, bit 7 of each byte dropped
  assign word = bi[3] ? cfg_i.numbers_high : cfg_i.numbers_low;

  always_comb begin
    res_o                    = '0;
    res_o.valid              = in_range && deb && emit;
    res_o.item.message_kind  = kind;
    res_o.item.midi_number   = word[{bi[2:0], 3'b000} +: 7];
    res_o.item.velocity      = vel;
    res_o.item.source_button = bi;
    res_o.item.report_id     = cfg_i.id_report_enable;
  end

  // State update as the item passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        hist_q[i]    <= '0;
        pressed_q[i] <= 1'b0;
        last_q[i]    <= 1'b0;
      end
    end else if (go_i && in_range) begin
      hist_q[ix] <= hist_new;
      if (deb) begin
        pressed_q[ix] <= pressed_nx;
        last_q[ix]    <= lvl;
      end
    end
  end

`ifndef SYNTHESIS
  // Program change never carries a velocity
  a_pc_vel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.item.message_kind == KIND_PROG_CHANGE) |->
      (res_o.item.velocity == 7'd0))
    else $error("program change with nonzero velocity");

  // No event without a debounced sample
  a_event_needs_deb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> deb && in_range)
    else $error("event without debounced sample");
`endif

endmodule

[hw/rtl/debounced_button_midi_events.sv]
// ----------------------------------------------------------------------------
// debounced_button_midi_events
// Debounces raw button samples and turns them into MIDI note/program events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one raw sample
//   per transaction: button index and level. Each sample is shifted into
//   that button's 8-bit history; seven equal samples in a row debounce it.
//   Output channel (out_valid_o / out_stall_i / out_item_o) carries at most
//   one MIDI event per sample: kind, number, velocity, button, ID flag.
//   An event moves from the input register to the result register when
//   the result register is free, and the receiver takes it from there.
//   Throughput: one sample per cycle unless the receiver stalls, set by
//   the per-button read-modify-write of the history and press flags
//   between the registers. When the receiver stalls, the result register
//   holds its event and the input register holds the next sample;
//   in_stall_o rises only while both are full. Samples that cause no
//   event pass with no output.
//   Configuration is written through the APB-style port, by the user only
//   while idle; the block does not enforce it. Registers sit at byte 8*i.
//   Reset clears all button histories and flags; the first 0 sample after
//   reset debounces silently. Velocity-on resets to 127, others to 0.
// ----------------------------------------------------------------------------
module debounced_button_midi_events #(
  parameter int unsigned BUTTON_COUNT = dmb_pkg::ButtonCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dmb_pkg::dmb_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dmb_pkg::dmb_out_t             out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmb_pkg::CfgAddrW-1:0]  paddr,
  input  logic [dmb_pkg::CfgDataW-1:0]  pwdata,
  output logic [dmb_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import dmb_pkg::*;

  dmb_cfg_t cfg;
  dmb_res_t res;

  logic     s1_valid_q, s1_valid_d;
  dmb_in_t  s1_item_q;
  logic     out_valid_q, out_valid_d;
  dmb_out_t out_q;
  logic     out_free;
  logic     advance;
  logic     in_take;

  // Configuration registers
  dmb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Event logic and per-button state
  dmb_core #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
    if (advance && res.valid) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // Input stalls only while a sample waits in the input register
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // A waiting sample is not dropped while the output is held
  a_s1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && $stable(s1_item_q))
    else $error("sample lost under output stall");

  // A held result is not overwritten by a passing sample
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !advance)
    else $error("result register overwritten while held");
`endif

endmodule

[tb/debounced_button_midi_events_checker.sv]
// ----------------------------------------------------------------------------
// debounced_button_midi_events_checker
// Watches both channels and the config port of the debounced button MIDI
// block, keeps its own copy of the per-button debounce state, predicts the
// MIDI event of every accepted sample and compares each event leaving the
// block against the oldest prediction.
// ----------------------------------------------------------------------------
module debounced_button_midi_events_checker
  import dmb_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = ButtonCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  dmb_in_t             in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  dmb_out_t            out_item_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [CfgDataW-1:0] pwdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the register file and of the per-button state
  dmb_cfg_t    cfg;
  logic [7:0]  history [16];
  logic [15:0] held;
  logic [15:0] level_seen;

  dmb_out_t    expected_events [$];
  dmb_out_t    predicted;
  dmb_out_t    want;
  int unsigned mismatches;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    mismatches   = 0;
  end

  // Debounce one sample and work out the event it causes, if any
  function automatic logic predict_event(input dmb_in_t s, output dmb_out_t ev);
    logic [3:0]  b;
    logic [7:0]  h;
    logic [62:0] word;
    logic        pc;
    logic        hit;
    b    = s.button_index;
    hit  = 1'b0;
    ev   = '0;
    ev.source_button = b;
    ev.report_id     = cfg.id_report_enable;
    word = b[3] ? cfg.numbers_high : cfg.numbers_low;
    // bit 7 of each number byte is dropped
    ev.midi_number = 7'(word >> (8 * b[2:0]));
    pc   = cfg.program_change_mask[b];
    // samples of buttons beyond the configured count are ignored
    if (int'(b) >= int'(BUTTON_COUNT)) return 1'b0;
    h = {history[b][6:0], s.raw_level} | HistForce;
    history[b] = h;
    if (h != HistForce && h != HistHigh) return 1'b0;
    if (cfg.latching_mask[b]) begin
      // toggle on rising edge only, falling edge is silent
      if (s.raw_level && !level_seen[b]) begin
        hit = 1'b1;
        ev.message_kind = held[b] ? KIND_NOTE_OFF : KIND_NOTE_ON;
        ev.velocity     = held[b] ? cfg.velocity_off_value : cfg.velocity_on_value;
        held[b]         = ~held[b];
      end
    end else if (s.raw_level) begin
      if (!held[b]) begin
        hit     = 1'b1;
        held[b] = 1'b1;
        ev.message_kind = pc ? KIND_PROG_CHANGE : KIND_NOTE_ON;
        ev.velocity     = pc ? 7'd0 : cfg.velocity_on_value;
      end
    end else if (held[b]) begin
      // program change buttons release silently
      hit     = !pc;
      held[b] = 1'b0;
      ev.message_kind = KIND_NOTE_OFF;
      ev.velocity     = cfg.velocity_off_value;
    end
    level_seen[b] = s.raw_level;
    return hit;
  endfunction

  function automatic string describe(input dmb_out_t e);
    return $sformatf("kind=%0d number=%0d velocity=%0d button=%0d id=%0b",
                     e.message_kind, e.midi_number, e.velocity, e.source_button,
                     e.report_id);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '0;
      cfg.velocity_on_value = 7'd127;
      for (int i = 0; i < 16; i++) history[i] = '0;
      held       = '0;
      level_seen = '0;
      expected_events.delete();
    end else begin
      // config write snoop
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[CfgAddrW-1:3]))
          REG_LATCHING_MASK: cfg.latching_mask       = pwdata_i[15:0];
          REG_PC_MASK:       cfg.program_change_mask = pwdata_i[15:0];
          REG_NUMBERS_LOW:   cfg.numbers_low         = pwdata_i[62:0];
          REG_NUMBERS_HIGH:  cfg.numbers_high        = pwdata_i[62:0];
          REG_VELOCITY_ON:   cfg.velocity_on_value   = pwdata_i[6:0];
          REG_VELOCITY_OFF:  cfg.velocity_off_value  = pwdata_i[6:0];
          REG_ID_REPORT:     cfg.id_report_enable    = pwdata_i[0];
          default: ;
        endcase
      end

      // outgoing event transaction
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, got %s", $time,
                   describe(out_item_i));
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (want.message_kind  !== out_item_i.message_kind ||
              want.midi_number   !== out_item_i.midi_number ||
              want.velocity      !== out_item_i.velocity ||
              want.source_button !== out_item_i.source_button ||
              want.report_id     !== out_item_i.report_id) begin
            $display("%0t: event mismatch, expected %s, got %s", $time,
                     describe(want), describe(out_item_i));
            mismatches++;
          end
        end
      end

      // incoming sample transaction
      if (in_valid_i && !in_stall_i) begin
        if (predict_event(in_item_i, predicted)) expected_events.push_back(predicted);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_events.size();
  end

endmodule

[tb/debounced_button_midi_events_tb.sv]
// ----------------------------------------------------------------------------
// debounced_button_midi_events_tb
// Drives raw button samples into the debounced button MIDI block: a short
// directed sequence, then phases of interleaved press/release runs with
// noise under several register settings, with random idle bursts on both
// channels. A separate checker predicts and compares every event.
// ----------------------------------------------------------------------------
module debounced_button_midi_events_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dmb_pkg::*;

  localparam int unsigned CycleLimit    = 200_000;
  localparam int          PhaseCount    = 6;
  localparam int          PhaseSamples  = 75;
  localparam int          SettleCycles  = 6;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  dmb_in_t             in_item_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  dmb_out_t            out_item_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  logic        quiet = 1'b0;
  int unsigned stall_left = 0;

  // per-button run generator: level, samples left, noisy run
  bit          run_level [16];
  int          run_left  [16];
  bit          run_noisy [16];
  logic [3:0]  active    [4];

  debounced_button_midi_events u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  debounced_button_midi_events_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // random receiver stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic [3:0] b, input logic lvl);
    in_valid_i <= 1'b1;
    in_item_i  <= '{button_index: b, raw_level: lvl};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic maybe_gap(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // hold off until every predicted event is out and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_e r, input logic [CfgDataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // register settings per phase: extreme values in the first three, the rest random
  task automatic configure(input int p);
    logic [15:0] lat;
    logic [15:0] pcm;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [6:0]  von;
    logic [6:0]  voff;
    logic        idr;
    lat  = 16'($urandom);
    pcm  = 16'($urandom);
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    von  = 7'($urandom);
    voff = 7'($urandom);
    idr  = 1'($urandom);
    case (p)
      0: begin
        lat = '0; pcm = '0; von = 7'd127; voff = '0; idr = 1'b0;
      end
      1: begin
        lat = '1; von = '0; voff = 7'd127; idr = 1'b1;
      end
      2: begin
        lat = '0; pcm = '1; lo = '1; hi = '1; von = 7'd127; voff = '0; idr = 1'b0;
      end
      default: ;
    endcase
    cfg_write(REG_LATCHING_MASK, 64'(lat));
    cfg_write(REG_PC_MASK,       64'(pcm));
    cfg_write(REG_NUMBERS_LOW,   lo);
    cfg_write(REG_NUMBERS_HIGH,  hi);
    cfg_write(REG_VELOCITY_ON,   64'(von));
    cfg_write(REG_VELOCITY_OFF,  64'(voff));
    cfg_write(REG_ID_REPORT,     64'(idr));
  endtask

  // mostly clean runs of 7 or 8 equal samples, some short noisy runs
  task automatic next_sample(output logic [3:0] b, output logic lvl);
    b = active[$urandom_range(0, 3)];
    if (run_left[b] == 0) begin
      run_noisy[b] = ($urandom_range(0, 6) == 0);
      run_left[b]  = run_noisy[b] ? $urandom_range(1, 4) : $urandom_range(7, 8);
      if ($urandom_range(0, 3) != 0) run_level[b] = ~run_level[b];
    end
    lvl = run_noisy[b] ? 1'($urandom_range(0, 1)) : run_level[b];
    run_left[b]--;
  endtask

  initial begin
    logic [3:0] b;
    logic       lvl;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fresh zero debounces silently, press/release on button 0, press on button 15
    send_sample(4'd0, 1'b0);
    repeat (7) send_sample(4'd0, 1'b1);
    maybe_gap(1'b1);
    repeat (7) send_sample(4'd0, 1'b0);
    repeat (7) begin
      send_sample(4'd15, 1'b1);
      maybe_gap(1'b1);
    end

    // random phases under changing settings
    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      configure(p);
      for (int k = 0; k < 4; k++) active[k] = 4'($urandom_range(0, 15));
      if (p == PhaseCount - 1) quiet <= 1'b1;
      for (int i = 0; i < PhaseSamples; i++) begin
        next_sample(b, lvl);
        send_sample(b, lvl);
        if (p == 3 && i == 40) settle();
        else maybe_gap(p != PhaseCount - 1);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dmb_pkg.sv
hw/rtl/dmb_cfg_regs.sv
hw/rtl/dmb_core.sv
hw/rtl/debounced_button_midi_events.sv
tb/debounced_button_midi_events_checker.sv
tb/debounced_button_midi_events_tb.sv
